[sv/assert_macros.svh]
// Concurrent assertion helpers shared by the segmentation RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every sampled edge outside reset.
`define CBS_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CBS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/cbs_pkg.sv]
// Code block segmentation package: field widths, defaults and the
// interleaver size table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbs_pkg;

  localparam int BLOCK_BITS_W   = 19;
  localparam int BLOCK_BITS_MAX = 2**BLOCK_BITS_W - 1;
  localparam int NUM_BLOCKS_W   = 7;
  localparam int CRC_LEN_W      = 5;
  localparam int TOTAL_BITS_W   = 20;
  localparam int K_W            = 13;
  localparam int COUNT_W        = 7;
  localparam int FILLER_W       = 13;
  localparam int TABLE_INDEX_W  = 8;
  localparam int SHIFT_W        = 3;

  localparam int CRC_BITS               = 24;
  localparam int DEF_MAX_BLOCK_SIZE     = 6144;
  localparam int DEF_SIZE_TABLE_ENTRIES = 188;
  localparam int RECIP_SHIFT            = 21;
  localparam int QUEUE_DEPTH            = 2;

  localparam int FULL_TABLE = 188;
  localparam int SEG1_START = 60;
  localparam int SEG2_START = 92;
  localparam int SEG3_START = 124;
  localparam int SEG0_BASE  = 40;
  localparam int SEG1_BASE  = 528;
  localparam int SEG2_BASE  = 1056;
  localparam int SEG3_BASE  = 2112;
  localparam int K_LAST     = 6144;

  function automatic logic [K_W-1:0] size_at(input logic [TABLE_INDEX_W-1:0] idx);
    logic [K_W-1:0] ie;
    logic [K_W-1:0] k;
    ie = K_W'(idx);
    priority if (idx < TABLE_INDEX_W'(SEG1_START)) begin
      k = K_W'(SEG0_BASE) + (ie << 3);
    end else if (idx < TABLE_INDEX_W'(SEG2_START)) begin
      k = K_W'(SEG1_BASE) + ((ie - K_W'(SEG1_START)) << 4);
    end else if (idx < TABLE_INDEX_W'(SEG3_START)) begin
      k = K_W'(SEG2_BASE) + ((ie - K_W'(SEG2_START)) << 5);
    end else if (idx < TABLE_INDEX_W'(FULL_TABLE)) begin
      k = K_W'(SEG3_BASE) + ((ie - K_W'(SEG3_START)) << 6);
    end else begin
      k = K_W'(K_LAST);
    end
    return k;
  endfunction

  // Gap between neighboring sizes is always a power of two.
  function automatic logic [SHIFT_W-1:0] step_shift(input logic [K_W-1:0] delta);
    logic [SHIFT_W-1:0] sh;
    unique case (delta)
      K_W'(8):  sh = SHIFT_W'(3);
      K_W'(16): sh = SHIFT_W'(4);
      K_W'(32): sh = SHIFT_W'(5);
      K_W'(64): sh = SHIFT_W'(6);
      default:  sh = SHIFT_W'(3);
    endcase
    return sh;
  endfunction

endpackage

`default_nettype wire

[sv/cbs_in_if.sv]
// Input channel: valid/ready handshake carrying the transport block length.
// Depends on cbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cbs_in_if;
  logic                           valid;
  logic                           ready;
  logic [cbs_pkg::BLOCK_BITS_W-1:0] block_bits;

  modport source (output valid, output block_bits, input ready);
  modport sink   (input valid, input block_bits, output ready);
endinterface

`default_nettype wire

[sv/cbs_out_if.sv]
// Result channel: valid/ready handshake carrying the segmentation result.
// Depends on cbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cbs_out_if;
  logic                             valid;
  logic                             ready;
  logic [cbs_pkg::NUM_BLOCKS_W-1:0]  num_blocks;
  logic [cbs_pkg::CRC_LEN_W-1:0]     crc_len;
  logic [cbs_pkg::TOTAL_BITS_W-1:0]  total_bits;
  logic [cbs_pkg::K_W-1:0]           k_plus;
  logic [cbs_pkg::K_W-1:0]           k_minus;
  logic [cbs_pkg::COUNT_W-1:0]       count_plus;
  logic [cbs_pkg::COUNT_W-1:0]       count_minus;
  logic [cbs_pkg::FILLER_W-1:0]      filler_bits;
  logic [cbs_pkg::TABLE_INDEX_W-1:0] table_index;

  modport source (output valid, output num_blocks, output crc_len, output total_bits,
                  output k_plus, output k_minus, output count_plus, output count_minus,
                  output filler_bits, output table_index, input ready);
  modport sink   (input valid, input num_blocks, input crc_len, input total_bits,
                  input k_plus, input k_minus, input count_plus, input count_minus,
                  input filler_bits, input table_index, output ready);
endinterface

`default_nettype wire

[sv/cbs_queue.sv]
// Short register FIFO between the classifier and the size search.
// Depends on cbs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cbs_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = cbs_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `CBS_CHECK(a_fill_bound, count_r <= CNT_W'(DEPTH), "queue fill above depth")
  `CBS_CHECK_NEXT(a_push_only, push && !pop, count_r == $past(count_r) + 1'b1, "fill missed a push")
  `CBS_CHECK_NEXT(a_pop_only, pop && !push, count_r == $past(count_r) - 1'b1, "fill missed a pop")

endmodule

`default_nettype wire

[sv/cbs_front.sv]
// Front end: takes a length, decides single or segmented and computes the
// block count C and B' by reciprocal multiply. Depends on cbs_pkg, cbs_in_if.
`timescale 1ns / 1ps
`default_nettype none

module cbs_front #(
  parameter int MAX_BLOCK_SIZE = cbs_pkg::DEF_MAX_BLOCK_SIZE
) (
  input  logic clk,
  input  logic rst_n,
  cbs_in_if.sink in_ch,
  output logic item_valid,
  input  logic item_ready,
  output logic [(1 + $clog2((cbs_pkg::BLOCK_BITS_MAX + MAX_BLOCK_SIZE - cbs_pkg::CRC_BITS - 1)
                / (MAX_BLOCK_SIZE - cbs_pkg::CRC_BITS) + 1)
                + $clog2(cbs_pkg::BLOCK_BITS_MAX + cbs_pkg::CRC_BITS
                * ((cbs_pkg::BLOCK_BITS_MAX + MAX_BLOCK_SIZE - cbs_pkg::CRC_BITS - 1)
                / (MAX_BLOCK_SIZE - cbs_pkg::CRC_BITS)) + 1)) - 1:0] item
);

  localparam int B_W     = cbs_pkg::BLOCK_BITS_W;
  localparam int ROOM    = MAX_BLOCK_SIZE - cbs_pkg::CRC_BITS;
  localparam int CMAX    = (cbs_pkg::BLOCK_BITS_MAX + ROOM - 1) / ROOM;
  localparam int C_W     = $clog2(CMAX + 1);
  localparam int BP_W    = $clog2(cbs_pkg::BLOCK_BITS_MAX + cbs_pkg::CRC_BITS * CMAX + 1);
  localparam int X_W     = $clog2(cbs_pkg::BLOCK_BITS_MAX + ROOM);
  localparam int RSH     = cbs_pkg::RECIP_SHIFT;
  localparam int RECIP   = (2**RSH) / ROOM;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int EST_W   = X_W + RECIP_W;

  logic             en;
  logic             v1_r, v2_r;
  logic [B_W-1:0]   b1_r;
  logic             big1_r, big2_r;
  logic [X_W-1:0]   x1_r, x_nxt;
  logic [EST_W-1:0] est1_r, est_nxt;
  logic             big_nxt;
  logic [C_W-1:0]   q, c_nxt, c2_r;
  logic [X_W-1:0]   qroom, rem;
  logic [BP_W-1:0]  bp_nxt, bp2_r;

  assign en          = !v2_r || item_ready;
  assign in_ch.ready = en;
  assign item_valid  = v2_r;
  assign item        = {big2_r, c2_r, bp2_r};

  always_comb begin
    big_nxt = (in_ch.block_bits > B_W'(MAX_BLOCK_SIZE));
    x_nxt   = X_W'(in_ch.block_bits) + X_W'(ROOM - 1);
    est_nxt = EST_W'(x_nxt) * EST_W'(RECIP);
  end

  // Estimate is exact or one low; a single compare fixes it.
  always_comb begin
    q      = C_W'(est1_r >> RSH);
    qroom  = X_W'(q) * X_W'(ROOM);
    rem    = x1_r - qroom;
    c_nxt  = big1_r ? ((rem >= X_W'(ROOM)) ? q + 1'b1 : q) : C_W'(1);
    bp_nxt = BP_W'(b1_r) + (big1_r ? BP_W'(c_nxt) * BP_W'(cbs_pkg::CRC_BITS) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_r   <= in_ch.block_bits;
      big1_r <= big_nxt;
      x1_r   <= x_nxt;
      est1_r <= est_nxt;
      big2_r <= big1_r;
      c2_r   <= c_nxt;
      bp2_r  <= bp_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/cbs_back.sv]
// Back end: binary search of the size table for K+, then K-, C+, C- and
// filler bits. Depends on cbs_pkg, cbs_out_if and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cbs_back #(
  parameter int MAX_BLOCK_SIZE     = cbs_pkg::DEF_MAX_BLOCK_SIZE,
  parameter int SIZE_TABLE_ENTRIES = cbs_pkg::DEF_SIZE_TABLE_ENTRIES
) (
  input  logic clk,
  input  logic rst_n,
  input  logic item_valid,
  output logic item_ready,
  input  logic [(1 + $clog2((cbs_pkg::BLOCK_BITS_MAX + MAX_BLOCK_SIZE - cbs_pkg::CRC_BITS - 1)
                / (MAX_BLOCK_SIZE - cbs_pkg::CRC_BITS) + 1)
                + $clog2(cbs_pkg::BLOCK_BITS_MAX + cbs_pkg::CRC_BITS
                * ((cbs_pkg::BLOCK_BITS_MAX + MAX_BLOCK_SIZE - cbs_pkg::CRC_BITS - 1)
                / (MAX_BLOCK_SIZE - cbs_pkg::CRC_BITS)) + 1)) - 1:0] item,
  cbs_out_if.source out_ch
);

  localparam int K_W    = cbs_pkg::K_W;
  localparam int SH_W   = cbs_pkg::SHIFT_W;
  localparam int TI_W   = cbs_pkg::TABLE_INDEX_W;
  localparam int ROOM   = MAX_BLOCK_SIZE - cbs_pkg::CRC_BITS;
  localparam int CMAX   = (cbs_pkg::BLOCK_BITS_MAX + ROOM - 1) / ROOM;
  localparam int C_W    = $clog2(CMAX + 1);
  localparam int BP_W   = $clog2(cbs_pkg::BLOCK_BITS_MAX + cbs_pkg::CRC_BITS * CMAX + 1);
  localparam int ITEM_W = 1 + C_W + BP_W;
  localparam int N      = SIZE_TABLE_ENTRIES;
  localparam int IDX_W  = (N > 1) ? $clog2(N) : 1;
  localparam int S      = IDX_W + 4;
  localparam int MUL_W  = C_W + K_W;
  localparam int CMP_W  = (MUL_W > BP_W) ? MUL_W : BP_W;

  typedef struct packed {
    logic             big;
    logic [C_W-1:0]   c;
    logic [BP_W-1:0]  bp;
    logic [IDX_W-1:0] p;
  } srch_t;

  typedef struct packed {
    logic                         big;
    logic                         hm;
    logic [C_W-1:0]               c;
    logic [BP_W-1:0]              bp;
    logic [IDX_W-1:0]             p;
    logic [K_W-1:0]               kp;
    logic [K_W-1:0]               km;
    logic [SH_W-1:0]              sh;
    logic [MUL_W-1:0]             prod;
    logic [MUL_W-1:0]             qv;
    logic [C_W-1:0]               cp;
    logic [C_W-1:0]               cm;
    logic [MUL_W-1:0]             used;
    logic [cbs_pkg::FILLER_W-1:0] f;
  } post_t;

  logic         en;
  logic [S-1:0] v_r;
  srch_t        s_r [IDX_W];
  srch_t        sl;
  post_t        a_nxt, a_r, b_nxt, b_r, c_nxt, c_r, d_nxt, d_r;
  logic [K_W-1:0]   km_full;
  logic [CMP_W-1:0] slack, spill;

  assign en         = !v_r[S-1] || out_ch.ready;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[S-2:0], item_valid};
    end
  end

  // One stage per index bit, MSB first: p counts sizes with C*K < B'.
  for (genvar j = 0; j < IDX_W; j++) begin : g_srch
    localparam int K = IDX_W - 1 - j;
    srch_t            cur, nxt;
    logic [IDX_W:0]   cand;
    logic [IDX_W-1:0] tidx;
    logic [MUL_W-1:0] mul;
    logic             take;

    if (j == 0) begin : g_head
      assign cur = '{big: item[ITEM_W-1], c: item[ITEM_W-2:BP_W], bp: item[BP_W-1:0],
                     p: '0};
    end else begin : g_tail
      assign cur = s_r[j-1];
    end

    always_comb begin
      cand = (IDX_W+1)'(cur.p) + (IDX_W+1)'(2**K);
      tidx = IDX_W'(cand - 1'b1);
      mul  = MUL_W'(cur.c) * MUL_W'(cbs_pkg::size_at(TI_W'(tidx)));
      take = (cand <= (IDX_W+1)'(N - 1)) && (CMP_W'(mul) < CMP_W'(cur.bp));
      nxt  = cur;
      if (take) begin
        nxt.p = cand[IDX_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[j] <= nxt;
      end
    end
  end

  assign sl = s_r[IDX_W-1];

  always_comb begin
    a_nxt      = '0;
    a_nxt.big  = sl.big;
    a_nxt.c    = sl.c;
    a_nxt.bp   = sl.bp;
    a_nxt.p    = sl.p;
    a_nxt.hm   = (sl.c != C_W'(1)) && (sl.p != '0);
    a_nxt.kp   = cbs_pkg::size_at(TI_W'(sl.p));
    km_full    = cbs_pkg::size_at(TI_W'(sl.p - 1'b1));
    a_nxt.km   = a_nxt.hm ? km_full : '0;
    a_nxt.sh   = cbs_pkg::step_shift(a_nxt.kp - km_full);
    a_nxt.prod = MUL_W'(sl.c) * MUL_W'(a_nxt.kp);
  end

  always_comb begin
    b_nxt    = a_r;
    slack    = (CMP_W'(a_r.prod) > CMP_W'(a_r.bp)) ?
               CMP_W'(a_r.prod) - CMP_W'(a_r.bp) : '0;
    b_nxt.qv = a_r.hm ? MUL_W'(slack >> a_r.sh) : '0;
  end

  always_comb begin
    c_nxt      = b_r;
    c_nxt.cm   = (b_r.qv > MUL_W'(b_r.c)) ? b_r.c : C_W'(b_r.qv);
    c_nxt.cp   = b_r.c - c_nxt.cm;
    c_nxt.used = b_r.prod - (MUL_W'(c_nxt.cm) << b_r.sh);
  end

  always_comb begin
    d_nxt   = c_r;
    spill   = (CMP_W'(c_r.used) > CMP_W'(c_r.bp)) ?
              CMP_W'(c_r.used) - CMP_W'(c_r.bp) : '0;
    d_nxt.f = cbs_pkg::FILLER_W'(spill);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
      d_r <= d_nxt;
    end
  end

  assign out_ch.valid       = v_r[S-1];
  assign out_ch.num_blocks  = cbs_pkg::NUM_BLOCKS_W'(d_r.c);
  assign out_ch.crc_len     = d_r.big ? cbs_pkg::CRC_LEN_W'(cbs_pkg::CRC_BITS) : '0;
  assign out_ch.total_bits  = cbs_pkg::TOTAL_BITS_W'(d_r.bp);
  assign out_ch.k_plus      = d_r.kp;
  assign out_ch.k_minus     = d_r.km;
  assign out_ch.count_plus  = cbs_pkg::COUNT_W'(d_r.cp);
  assign out_ch.count_minus = cbs_pkg::COUNT_W'(d_r.cm);
  assign out_ch.filler_bits = d_r.f;
  assign out_ch.table_index = TI_W'(d_r.p);

  `CBS_CHECK(a_split_sum, !v_r[S-1] || ((C_W+1)'(d_r.cp) + (C_W+1)'(d_r.cm) == (C_W+1)'(d_r.c)), "C+ plus C- differs from C")
  `CBS_CHECK(a_single_block, !(v_r[S-1] && !d_r.big) || (d_r.c == C_W'(1) && d_r.cm == '0), "unsegmented length with split")
  `CBS_CHECK(a_segmented, !(v_r[S-1] && d_r.big) || (d_r.c > C_W'(1)), "segmented length with one block")

endmodule

`default_nettype wire

[sv/code_block_segmentation_params.sv]
// Turbo code block segmentation: one transport block length in, one result out.
// Throughput: one length per cycle while out_ch.ready is high. Each length passes through the
// front end registers, the queue, the one-bit-per-stage search over the size table and the
// post-search stages a_r, b_r, c_r and d_r before the result shows.
// Reset (rst_n low, synchronous) empties all stages and the queue; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module code_block_segmentation_params #(
  parameter int MAX_BLOCK_SIZE     = cbs_pkg::DEF_MAX_BLOCK_SIZE,
  parameter int SIZE_TABLE_ENTRIES = cbs_pkg::DEF_SIZE_TABLE_ENTRIES
) (
  input  logic clk,
  input  logic rst_n,
  cbs_in_if.sink    in_ch,
  cbs_out_if.source out_ch
);

  localparam int ROOM   = MAX_BLOCK_SIZE - cbs_pkg::CRC_BITS;
  localparam int CMAX   = (cbs_pkg::BLOCK_BITS_MAX + ROOM - 1) / ROOM;
  localparam int C_W    = $clog2(CMAX + 1);
  localparam int BP_W   = $clog2(cbs_pkg::BLOCK_BITS_MAX + cbs_pkg::CRC_BITS * CMAX + 1);
  localparam int ITEM_W = 1 + C_W + BP_W;

  logic              f_valid, f_ready;
  logic [ITEM_W-1:0] f_item;
  logic              b_valid, b_ready;
  logic [ITEM_W-1:0] b_item;

  cbs_front #(
    .MAX_BLOCK_SIZE (MAX_BLOCK_SIZE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  cbs_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (cbs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_item)
  );

  cbs_back #(
    .MAX_BLOCK_SIZE     (MAX_BLOCK_SIZE),
    .SIZE_TABLE_ENTRIES (SIZE_TABLE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (b_valid),
    .item_ready (b_ready),
    .item       (b_item),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
